### hw/rtl/register_memory_instruction_executor_assert.svh
// ============================================================================
// Assertion macros for the register/memory instruction executor
// Concurrent checks on internal control; ASSERT_OFF compiles them out.
// ============================================================================
`ifndef REGISTER_MEMORY_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define REGISTER_MEMORY_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold on every clock edge outside reset
`define RME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define RME_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RME_ASSERT(lbl, clk, rst_n, prop, msg)
`define RME_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/rme_pkg.sv
// ============================================================================
// rme_pkg
// Shared types and constants of the register/memory instruction executor.
// ============================================================================
package rme_pkg;

    localparam int DEF_MEM_BYTES   = 65536;
    localparam int DEF_IP_INDEX    = 31;
    localparam int DEF_INSTR_BYTES = 16;

    localparam int DATA_W      = 64;
    localparam int WORD_BYTES  = DATA_W / 8;
    localparam int NUM_REGS    = 32;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int KIND_W      = 3;
    localparam int QUEUE_DEPTH = 2;

    // opcodes as they arrive on the input beat
    typedef enum logic [KIND_W-1:0] {
        OP_MOVE  = 3'd0,
        OP_SHL   = 3'd1,
        OP_SHR   = 3'd2,
        OP_LOAD  = 3'd3,
        OP_STORE = 3'd4,
        OP_HALT  = 3'd5
    } t_op;

    // operation class after decode; unknown opcodes become EX_NOP
    typedef enum logic [2:0] {
        EX_MOVE,
        EX_SHL,
        EX_SHR,
        EX_LOAD,
        EX_STORE,
        EX_HALT,
        EX_NOP
    } t_exec;

    typedef enum logic [1:0] {
        ST_READ,
        ST_EXEC,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [REG_IDX_W-1:0] src_reg;
        logic [REG_IDX_W-1:0] dst_reg;
        logic [DATA_W-1:0]    imm_value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] dest_value;
        logic              access_skipped;
        logic              unknown_op;
        logic              halted;
    } t_out_item;

    typedef struct packed {
        t_exec                op;
        logic                 imm_nz;
        logic [REG_IDX_W-1:0] src;
        logic [REG_IDX_W-1:0] dst;
        logic [DATA_W-1:0]    imm;
    } t_cmd;

    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [WORD_BYTES-1:0] even_be;
        logic [WORD_BYTES-1:0] odd_be;
    } t_mem_ctl;

endpackage

### hw/rtl/rme_front.sv
// ============================================================================
// rme_front
// Input side: accepts instruction beats and decodes them into queue commands.
// ============================================================================
module rme_front import rme_pkg::*; (
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    input  logic     i_clr_busy,
    output logic     o_in_ready,
    output logic     o_push,
    output t_cmd     o_cmd
);

    assign o_in_ready = !i_q_full && !i_clr_busy;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.src    = i_in_item.src_reg;
        o_cmd.dst    = i_in_item.dst_reg;
        o_cmd.imm    = i_in_item.imm_value;
        o_cmd.imm_nz = |i_in_item.imm_value;
        unique case (t_op'(i_in_item.kind))
            OP_MOVE:  o_cmd.op = EX_MOVE;
            OP_SHL:   o_cmd.op = EX_SHL;
            OP_SHR:   o_cmd.op = EX_SHR;
            OP_LOAD:  o_cmd.op = EX_LOAD;
            OP_STORE: o_cmd.op = EX_STORE;
            OP_HALT:  o_cmd.op = EX_HALT;
            default:  o_cmd.op = EX_NOP;
        endcase
    end

endmodule

### hw/rtl/rme_fifo.sv
// ============================================================================
// rme_fifo
// Short command queue between the decode front and the execution back end.
// ============================================================================
module rme_fifo import rme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    assign o_head  = r_buf[r_rd_ptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));

endmodule

### hw/rtl/rme_dmem.sv
// ============================================================================
// rme_dmem
// Byte-addressed data memory as two 64-bit banks (even and odd words), so an
// unaligned 8-byte access touches each bank once. Zeroed by a sweep on reset.
// ============================================================================
module rme_dmem import rme_pkg::*; #(
    parameter  int MEM_BYTES = DEF_MEM_BYTES,
    localparam int BANK_ROWS = (MEM_BYTES + 2 * WORD_BYTES - 1) / (2 * WORD_BYTES),
    localparam int ROW_W     = $clog2(BANK_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_ctl          i_ctl,
    input  logic [ROW_W-1:0]  i_even_row,
    input  logic [ROW_W-1:0]  i_odd_row,
    input  logic [DATA_W-1:0] i_even_wdata,
    input  logic [DATA_W-1:0] i_odd_wdata,
    output logic [DATA_W-1:0] o_even_q,
    output logic [DATA_W-1:0] o_odd_q,
    output logic              o_busy
);

    logic [DATA_W-1:0] r_even [BANK_ROWS];
    logic [DATA_W-1:0] r_odd  [BANK_ROWS];
    logic [DATA_W-1:0] r_even_q, r_odd_q;
    logic              r_busy;
    logic [ROW_W-1:0]  r_clr_row;

    // clearing sweep, one row of both banks per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            if (r_clr_row == ROW_W'(BANK_ROWS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_even[r_clr_row] <= '0;
            r_odd[r_clr_row]  <= '0;
        end else if (i_ctl.wr_en) begin
            for (int b = 0; b < WORD_BYTES; b++) begin
                if (i_ctl.even_be[b]) begin
                    r_even[i_even_row][b*8 +: 8] <= i_even_wdata[b*8 +: 8];
                end
                if (i_ctl.odd_be[b]) begin
                    r_odd[i_odd_row][b*8 +: 8] <= i_odd_wdata[b*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_even_q <= r_even[i_even_row];
            r_odd_q  <= r_odd[i_odd_row];
        end
    end

    assign o_even_q = r_even_q;
    assign o_odd_q  = r_odd_q;
    assign o_busy   = r_busy;

endmodule

### hw/rtl/rme_back.sv
// ============================================================================
// rme_back
// Execution back end: register file, operand read, shift/move/address unit,
// data memory access sequencing, IP update and the result output register.
// ============================================================================
module rme_back import rme_pkg::*; #(
    parameter  int MEM_BYTES   = DEF_MEM_BYTES,
    parameter  int IP_INDEX    = DEF_IP_INDEX,
    parameter  int INSTR_BYTES = DEF_INSTR_BYTES,
    localparam int BANK_ROWS   = (MEM_BYTES + 2 * WORD_BYTES - 1) / (2 * WORD_BYTES),
    localparam int ROW_W       = $clog2(BANK_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output t_mem_ctl          o_mem_ctl,
    output logic [ROW_W-1:0]  o_even_row,
    output logic [ROW_W-1:0]  o_odd_row,
    output logic [DATA_W-1:0] o_even_wdata,
    output logic [DATA_W-1:0] o_odd_wdata,
    input  logic [DATA_W-1:0] i_even_q,
    input  logic [DATA_W-1:0] i_odd_q,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item
);

    localparam logic [DATA_W-1:0]    MEM_SIZE   = DATA_W'(MEM_BYTES);
    localparam logic [DATA_W-1:0]    ADDR_LIMIT = DATA_W'(MEM_BYTES - WORD_BYTES);
    localparam logic [DATA_W-1:0]    IP_STEP    = DATA_W'(INSTR_BYTES);
    localparam logic [REG_IDX_W-1:0] IP_REG     = REG_IDX_W'(IP_INDEX);
    localparam int                   OFF_W      = $clog2(WORD_BYTES);
    localparam int                   SH_W       = $clog2(DATA_W);

    t_state               r_state, n_state;
    t_cmd                 r_cmd;
    logic [DATA_W-1:0]    r_rf [NUM_REGS];
    logic [NUM_REGS-1:0]  r_rf_vld;
    logic [DATA_W-1:0]    r_src_q, r_dst_q;
    logic                 r_src_vld, r_dst_vld;
    logic [DATA_W-1:0]    r_ip;
    logic                 r_addr_ok;
    logic [OFF_W-1:0]     r_off;
    logic                 r_odd;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [DATA_W-1:0]       src_val, dst_val, operand, addr;
    logic [DATA_W-1:0]       wr_val, ip_mid, ip_new, load_word, lo_word, hi_word;
    logic                    addr_ok, wr_en, skip, finish, fire, out_free, dst_is_ip;
    logic [ROW_W:0]          word_lo, word_inc;
    logic [2*DATA_W-1:0]     load_pair, store_pair;
    logic [2*WORD_BYTES-1:0] store_be;

    // operands; the IP register lives in its own flop, entries never written read 0
    assign src_val   = (r_cmd.src == IP_REG) ? r_ip : (r_src_vld ? r_src_q : '0);
    assign dst_val   = (r_cmd.dst == IP_REG) ? r_ip : (r_dst_vld ? r_dst_q : '0);
    assign operand   = r_cmd.imm_nz ? r_cmd.imm : src_val;
    assign dst_is_ip = (r_cmd.dst == IP_REG);
    assign out_free  = !r_out_valid || i_out_ready;

    // address: load uses src as base, store uses dst
    assign addr     = ((r_cmd.op == EX_LOAD) ? src_val : dst_val) + r_cmd.imm;
    assign addr_ok  = (addr < ADDR_LIMIT);
    assign word_lo  = addr[ROW_W+OFF_W:OFF_W];
    assign word_inc = word_lo + (ROW_W+1)'(1);

    // word w and w+1 split across banks: odd row w/2, even row (w+1)/2
    assign o_odd_row  = word_lo[ROW_W:1];
    assign o_even_row = word_inc[ROW_W:1];

    // store data and byte enables over the two-word window
    assign store_pair = {{DATA_W{1'b0}}, src_val} << (8 * addr[OFF_W-1:0]);
    assign store_be   = (2*WORD_BYTES)'({WORD_BYTES{1'b1}}) << addr[OFF_W-1:0];
    assign o_even_wdata = word_lo[0] ? store_pair[2*DATA_W-1:DATA_W]
                                     : store_pair[DATA_W-1:0];
    assign o_odd_wdata  = word_lo[0] ? store_pair[DATA_W-1:0]
                                     : store_pair[2*DATA_W-1:DATA_W];

    // load alignment
    assign lo_word   = r_odd ? i_odd_q : i_even_q;
    assign hi_word   = r_odd ? i_even_q : i_odd_q;
    assign load_pair = {hi_word, lo_word} >> (8 * r_off);
    assign load_word = load_pair[DATA_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_READ: begin
                if (!i_empty) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_cmd.op == EX_LOAD) begin
                    n_state = ST_LOAD;
                end else if (out_free) begin
                    n_state = ST_READ;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_state = ST_READ;
                end
            end
            default: n_state = ST_READ;
        endcase
    end

    // per-state outputs
    always_comb begin
        o_pop     = 1'b0;
        finish    = 1'b0;
        wr_en     = 1'b0;
        wr_val    = dst_val;
        skip      = 1'b0;
        o_mem_ctl = '0;
        unique case (r_state)
            ST_READ: begin
                o_pop = !i_empty;
            end
            ST_EXEC: begin
                unique case (r_cmd.op)
                    EX_MOVE: begin
                        finish = 1'b1;
                        wr_en  = 1'b1;
                        wr_val = operand;
                    end
                    EX_SHL: begin
                        finish = 1'b1;
                        wr_en  = 1'b1;
                        wr_val = (|operand[DATA_W-1:SH_W]) ? '0
                                                           : dst_val << operand[SH_W-1:0];
                    end
                    EX_SHR: begin
                        finish = 1'b1;
                        wr_en  = 1'b1;
                        wr_val = (|operand[DATA_W-1:SH_W]) ? '0
                                                           : dst_val >> operand[SH_W-1:0];
                    end
                    EX_LOAD: begin
                        o_mem_ctl.rd_en = addr_ok;
                    end
                    EX_STORE: begin
                        finish            = 1'b1;
                        skip              = !addr_ok;
                        o_mem_ctl.wr_en   = addr_ok && out_free;
                        o_mem_ctl.even_be = word_lo[0] ? store_be[2*WORD_BYTES-1:WORD_BYTES]
                                                       : store_be[WORD_BYTES-1:0];
                        o_mem_ctl.odd_be  = word_lo[0] ? store_be[WORD_BYTES-1:0]
                                                       : store_be[2*WORD_BYTES-1:WORD_BYTES];
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_LOAD: begin
                finish = 1'b1;
                wr_en  = r_addr_ok;
                wr_val = load_word;
                skip   = !r_addr_ok;
            end
            default: ;
        endcase
    end

    assign fire = finish && out_free;

    // IP: explicit write or halt first, then the instruction-size advance
    always_comb begin
        if (wr_en && dst_is_ip) begin
            ip_mid = wr_val;
        end else if (r_cmd.op == EX_HALT) begin
            ip_mid = MEM_SIZE;
        end else begin
            ip_mid = r_ip;
        end
        ip_new = ip_mid + IP_STEP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READ;
            r_rf_vld    <= '0;
            r_ip        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_ip <= ip_new;
                if (wr_en && !dst_is_ip) begin
                    r_rf_vld[r_cmd.dst] <= 1'b1;
                end
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // register file: two registered reads at dispatch, one write at retire
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd     <= i_head;
            r_src_q   <= r_rf[i_head.src];
            r_dst_q   <= r_rf[i_head.dst];
            r_src_vld <= r_rf_vld[i_head.src];
            r_dst_vld <= r_rf_vld[i_head.dst];
        end
        if (fire && wr_en && !dst_is_ip) begin
            r_rf[r_cmd.dst] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_addr_ok <= addr_ok;
            r_off     <= addr[OFF_W-1:0];
            r_odd     <= word_lo[0];
        end
        if (fire) begin
            r_out.dest_value     <= dst_is_ip ? ip_new : (wr_en ? wr_val : dst_val);
            r_out.access_skipped <= skip;
            r_out.unknown_op     <= (r_cmd.op == EX_NOP);
            r_out.halted         <= (ip_new >= MEM_SIZE);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### hw/rtl/register_memory_instruction_executor.sv
// ============================================================================
// register_memory_instruction_executor
// Executes one decoded instruction per input beat against 32 x 64-bit
// registers and a byte-addressed data memory of MEM_BYTES bytes, returning
// one result beat per instruction (new destination value, skipped-access,
// unknown-opcode and halted flags). Each instruction passes a registered
// register-file read and then a step that executes it or issues the
// data-memory read; a load adds a further step for the registered memory
// read data. A new beat is taken while earlier ones wait in the two-entry
// command queue or the output register. After reset the data memory is
// zeroed by a sweep over its ceil(MEM_BYTES/16) bank rows (4096 at the
// default size); no input beat is accepted until it completes.
// ============================================================================
`include "register_memory_instruction_executor_assert.svh"

module register_memory_instruction_executor import rme_pkg::*; #(
    parameter int MEM_BYTES   = DEF_MEM_BYTES,
    parameter int IP_INDEX    = DEF_IP_INDEX,
    parameter int INSTR_BYTES = DEF_INSTR_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int BANK_ROWS = (MEM_BYTES + 2 * WORD_BYTES - 1) / (2 * WORD_BYTES);
    localparam int ROW_W     = $clog2(BANK_ROWS);

    // front -> queue
    logic w_push, w_full, w_empty, w_pop, w_clr_busy;
    t_cmd w_cmd, w_head;

    // back -> data memory
    t_mem_ctl          w_mem_ctl;
    logic [ROW_W-1:0]  w_even_row, w_odd_row;
    logic [DATA_W-1:0] w_even_wdata, w_odd_wdata, w_even_q, w_odd_q;

    // decode and accept; stalls only on a full queue or during the memory sweep
    rme_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (w_full),
        .i_clr_busy (w_clr_busy),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    // decouples accept from execution
    rme_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // two-bank data memory with reset sweep
    rme_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_mem_ctl),
        .i_even_row   (w_even_row),
        .i_odd_row    (w_odd_row),
        .i_even_wdata (w_even_wdata),
        .i_odd_wdata  (w_odd_wdata),
        .o_even_q     (w_even_q),
        .o_odd_q      (w_odd_q),
        .o_busy       (w_clr_busy)
    );

    // sequencer, register file, IP and result register
    rme_back #(
        .MEM_BYTES   (MEM_BYTES),
        .IP_INDEX    (IP_INDEX),
        .INSTR_BYTES (INSTR_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_mem_ctl    (w_mem_ctl),
        .o_even_row   (w_even_row),
        .o_odd_row    (w_odd_row),
        .o_even_wdata (w_even_wdata),
        .o_odd_wdata  (w_odd_wdata),
        .i_even_q     (w_even_q),
        .i_odd_q      (w_odd_q),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

    // queue never overfilled or underflowed
    `RME_ASSERT(a_push_not_full, i_clk, i_rst_n, w_push |-> !w_full, "push into full queue")
    `RME_ASSERT(a_pop_not_empty, i_clk, i_rst_n, w_pop |-> !w_empty, "pop from empty queue")
    // nothing enters while the memory sweep runs
    `RME_ASSERT(a_no_push_clear, i_clk, i_rst_n, w_clr_busy |-> !w_push, "beat taken in sweep")
    // a bank is either read or written in one cycle, never both
    `RME_ASSERT_NEVER(a_mem_rd_wr, i_clk, i_rst_n, w_mem_ctl.rd_en && w_mem_ctl.wr_en, "rd+wr")

endmodule

### dv/tb_register_memory_instruction_executor.sv
// ============================================================================
// Testbench: register/memory instruction executor
// Feeds decoded instructions through the input handshake and checks every
// result beat against a cycle-free model of the register file and data
// memory. A directed opening covers shift limits, address boundaries,
// wraparound and writes to IP. Most random beats form store/load runs on a
// freshly set base register. Both sides idle at random, and the receiver
// holds off once for a long stretch so that the block backs up.
// ============================================================================
module tb_register_memory_instruction_executor;
    import rme_pkg::*;

    localparam int MEM_BYTES   = DEF_MEM_BYTES;
    localparam int IP_INDEX    = DEF_IP_INDEX;
    localparam int INSTR_BYTES = DEF_INSTR_BYTES;

    // an access must start below this address
    localparam logic [DATA_W-1:0] ACCESS_LIMIT = MEM_BYTES - WORD_BYTES;

    // opcodes that the package leaves undefined
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_AT_BEAT = 900;     // input beat count that starts the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;  // covers the memory clear after reset
    localparam int REPORT_LIMIT = 10;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    register_memory_instruction_executor #(
        .MEM_BYTES   (MEM_BYTES),
        .IP_INDEX    (IP_INDEX),
        .INSTR_BYTES (INSTR_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow machine state and bookkeeping
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] gpr [NUM_REGS];
    bit   [7:0]        mem_img [MEM_BYTES];   // bit type: starts zero like the DUT after clear

    t_in_item  instr_q[$];        // beats still to be offered
    t_out_item predicted_q[$];    // results owed by the DUT, oldest first

    int n_accepted  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int n_loads_ok  = 0;
    int n_stores_ok = 0;
    int n_skipped   = 0;
    int n_unknown   = 0;
    int n_halted    = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int cycle_count = 0;

    // Executes one instruction on the shadow state and queues its result.
    function automatic void execute_instr(t_in_item it);
        logic [DATA_W-1:0] operand;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] word;
        t_out_item         res;
        res     = '0;
        operand = (it.imm_value != '0) ? it.imm_value : gpr[it.src_reg];
        case (it.kind)
            OP_MOVE: begin
                gpr[it.dst_reg] = operand;
            end
            OP_SHL: begin
                gpr[it.dst_reg] = (operand >= DATA_W) ? '0 : gpr[it.dst_reg] << operand;
            end
            OP_SHR: begin
                gpr[it.dst_reg] = (operand >= DATA_W) ? '0 : gpr[it.dst_reg] >> operand;
            end
            OP_LOAD: begin
                addr = gpr[it.src_reg] + it.imm_value;
                if (addr < ACCESS_LIMIT) begin
                    for (int i = 0; i < WORD_BYTES; i++) begin
                        word[8*i +: 8] = mem_img[addr + i];
                    end
                    gpr[it.dst_reg] = word;
                    n_loads_ok++;
                end else begin
                    res.access_skipped = 1'b1;
                end
            end
            OP_STORE: begin
                // base comes from dst_reg, data from src_reg
                addr = gpr[it.dst_reg] + it.imm_value;
                if (addr < ACCESS_LIMIT) begin
                    for (int i = 0; i < WORD_BYTES; i++) begin
                        mem_img[addr + i] = gpr[it.src_reg][8*i +: 8];
                    end
                    n_stores_ok++;
                end else begin
                    res.access_skipped = 1'b1;
                end
            end
            OP_HALT: begin
                gpr[IP_INDEX] = MEM_BYTES;
            end
            default: begin
                res.unknown_op = 1'b1;
            end
        endcase
        // IP advance lands after any write to IP by the instruction itself
        gpr[IP_INDEX] = gpr[IP_INDEX] + INSTR_BYTES;
        res.dest_value = gpr[it.dst_reg];
        res.halted     = (gpr[IP_INDEX] >= MEM_BYTES);
        n_skipped += res.access_skipped;
        n_unknown += res.unknown_op;
        n_halted  += res.halted;
        predicted_q.push_back(res);
    endfunction

    function automatic void push_instr(logic [KIND_W-1:0] kind, int src, int dst,
                                       logic [DATA_W-1:0] imm);
        t_in_item it;
        it.kind      = kind;
        it.src_reg   = REG_IDX_W'(src);
        it.dst_reg   = REG_IDX_W'(dst);
        it.imm_value = imm;
        instr_q.push_back(it);
    endfunction

    // random register in 0..31 other than the one given
    function automatic int pick_reg_except(int taken);
        int r;
        r = $urandom_range(0, NUM_REGS - 2);
        return (r >= taken) ? r + 1 : r;
    endfunction

    // idle length: mostly none, some short, a few long; none at all when calm
    function automatic int idle_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void flag_error();
        n_errors++;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued beats, updates the shadow state on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                execute_instr(i_in_item);
                n_accepted++;
            end
            // slot is free when nothing is up or the current beat just went in
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (instr_q.size() != 0) begin
                    i_in_item  <= instr_q.pop_front();
                    i_in_valid <= 1'b1;
                    gap_left   = idle_len(((n_accepted / 200) % 4) == 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver ready: random stalls plus one long hold-off mid-run while the
    // driver keeps offering, so the command queue and output register fill
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left = idle_len(((n_results / 250) % 4) == 1);
            i_out_ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (predicted_q.size() == 0) begin
                flag_error();
                if (n_errors <= REPORT_LIMIT)
                    $display("result beat %0d with nothing outstanding: value %h skip %b unk %b halt %b",
                             n_results, o_out_item.dest_value, o_out_item.access_skipped,
                             o_out_item.unknown_op, o_out_item.halted);
            end else begin
                want = predicted_q.pop_front();
                if (want.dest_value     !== o_out_item.dest_value     ||
                    want.access_skipped !== o_out_item.access_skipped ||
                    want.unknown_op     !== o_out_item.unknown_op     ||
                    want.halted         !== o_out_item.halted) begin
                    flag_error();
                    if (n_errors <= REPORT_LIMIT) begin
                        $display("result beat %0d mismatch", n_results);
                        $display("  expected: value %h skip %b unk %b halt %b",
                                 want.dest_value, want.access_skipped,
                                 want.unknown_op, want.halted);
                        $display("  actual:   value %h skip %b unk %b halt %b",
                                 o_out_item.dest_value, o_out_item.access_skipped,
                                 o_out_item.unknown_op, o_out_item.halted);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int                n_gen;
        int                r;
        int                base_reg;
        int                data_reg;
        int                run_len;
        logic [DATA_W-1:0] base_addr;
        logic [DATA_W-1:0] imm;
        longint            offset;
        logic [KIND_W-1:0] kind;

        for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;

        // --- directed opening ---
        push_instr(OP_MOVE,  0, 1, '1);                 // all-ones immediate
        push_instr(OP_MOVE,  1, 2, '0);                 // zero immediate: copy r1
        push_instr(OP_SHL,   0, 2, 64'd4);
        push_instr(OP_SHR,   0, 2, 64'd63);             // largest legal shift
        push_instr(OP_MOVE,  0, 3, 64'd256);
        push_instr(OP_SHL,   0, 1, 64'd64);             // shift of 64 clears
        push_instr(OP_MOVE,  0, 4, 64'd7);
        push_instr(OP_SHL,   4, 2, '0);                 // shift amount from register
        push_instr(OP_SHR,   3, 2, '0);                 // register amount above 63
        push_instr(OP_MOVE,  0, 5, 64'h0123_4567_89ab_cdef);
        push_instr(OP_STORE, 5, 3, '0);
        push_instr(OP_LOAD,  3, 6, 64'd3);              // unaligned, overlaps the store
        push_instr(OP_LOAD,  3, 7, '0);                 // back-to-back load
        push_instr(OP_MOVE,  0, 8, MEM_BYTES - WORD_BYTES - 1);
        push_instr(OP_STORE, 5, 8, '0);                 // last legal address
        push_instr(OP_LOAD,  8, 9, 64'd1);              // first illegal address
        push_instr(OP_STORE, 5, 3, -64'd257);           // wraps to all-ones: skipped
        push_instr(OP_LOAD,  3, 10, -64'd256);          // wraps to address zero
        push_instr(KIND_UNUSED_LO, 2, 11, 64'd5);
        push_instr(KIND_UNUSED_HI, 5, 12, '1);
        push_instr(OP_MOVE,  0, IP_INDEX, MEM_BYTES - INSTR_BYTES);  // IP lands on the end
        push_instr(OP_MOVE,  0, IP_INDEX, -64'd8);      // IP advance wraps past 2^64
        push_instr(OP_HALT,  3, IP_INDEX, 64'd9);
        push_instr(OP_MOVE,  13, IP_INDEX, '0);         // IP from a zero register
        push_instr(OP_LOAD,  3, IP_INDEX, '0);          // IP loaded from memory

        // --- random part: mostly store/load runs around a freshly set base ---
        n_gen = 0;
        while (n_gen < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                base_reg  = $urandom_range(1, NUM_REGS - 2);
                base_addr = ($urandom_range(0, 99) < 85) ?
                            $urandom_range(16, 1023) :
                            $urandom_range(MEM_BYTES - 64, MEM_BYTES - WORD_BYTES - 1);
                push_instr(OP_MOVE, $urandom_range(0, NUM_REGS - 1), base_reg, base_addr);
                n_gen++;
                run_len = $urandom_range(1, 6);
                for (int k = 0; k < run_len; k++) begin
                    offset = longint'($urandom_range(0, 48)) - 16;
                    data_reg = pick_reg_except(base_reg);
                    if ($urandom_range(0, 1) == 1) begin
                        if ($urandom_range(0, 1) == 1) begin
                            push_instr(OP_MOVE, 0, data_reg, {$urandom, $urandom});
                            n_gen++;
                        end
                        push_instr(OP_STORE, ($urandom_range(0, 9) == 0) ? base_reg : data_reg,
                                   base_reg, offset);
                    end else begin
                        // load never overwrites the base inside the run
                        push_instr(OP_LOAD, base_reg, data_reg, offset);
                    end
                    n_gen++;
                end
            end else if (r < 80) begin
                r = $urandom_range(0, 2);
                kind = (r == 0) ? OP_MOVE : (r == 1) ? OP_SHL : OP_SHR;
                r = $urandom_range(0, 99);
                if (r < 30)      imm = '0;
                else if (r < 60) imm = $urandom_range(1, 63);
                else if (r < 70) imm = $urandom_range(64, 127);
                else             imm = {$urandom, $urandom};
                push_instr(kind, $urandom_range(0, NUM_REGS - 1),
                           $urandom_range(0, NUM_REGS - 1), imm);
                n_gen++;
            end else if (r < 88) begin
                // noise: every field random, accesses mostly out of range
                push_instr(KIND_W'($urandom_range(0, 7)), $urandom_range(0, NUM_REGS - 1),
                           $urandom_range(0, NUM_REGS - 1), {$urandom, $urandom});
                n_gen++;
            end else if (r < 94) begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    push_instr(OP_HALT, $urandom_range(0, NUM_REGS - 1),
                               $urandom_range(0, NUM_REGS - 1), {$urandom, $urandom});
                else if (r < 7)
                    push_instr(OP_MOVE, 0, IP_INDEX, $urandom_range(1, 4096));
                else
                    push_instr(OP_MOVE, 0, IP_INDEX,
                               MEM_BYTES - INSTR_BYTES * $urandom_range(0, 4));
                n_gen++;
            end else begin
                push_instr(($urandom_range(0, 1) == 1) ? KIND_UNUSED_HI : KIND_UNUSED_LO,
                           $urandom_range(0, NUM_REGS - 1), $urandom_range(0, NUM_REGS - 1),
                           {$urandom, $urandom});
                n_gen++;
            end
        end

        // single reset at the start of the run
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (predicted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d instructions, %0d result beats; %0d loads and %0d stores hit memory,",
                 n_accepted, n_results, n_loads_ok, n_stores_ok);
        $display("%0d accesses skipped, %0d unknown opcodes, %0d results with IP past the end.",
                 n_skipped, n_unknown, n_halted);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
